>>> rtl/core/pnc_pkg.sv
// ----------------------------------------------------------------------------
// pnc_pkg
// types and constants shared by the palette nearest color search blocks
// ----------------------------------------------------------------------------
`default_nettype none

package pnc_pkg;

    localparam int IDX_W   = 8;
    localparam int COLOR_W = 32;
    localparam int DIST_W  = 18;

    localparam logic [DIST_W-1:0] DIST_START = 18'd200000;

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_READ    = 2'd1,
        MODE_EXACT   = 2'd2,
        MODE_NEAREST = 2'd3
    } t_mode;

    // request token walking down the cell chain
    typedef struct packed {
        logic                vld;
        t_mode               mode;
        logic [IDX_W-1:0]    entry_index;
        logic [COLOR_W-1:0]  color;
        logic                alloc;
        logic [COLOR_W-1:0]  rd;
        logic                ex_hit;
        logic [IDX_W-1:0]    ex_idx;
        logic                near_hit;
        logic [IDX_W-1:0]    near_idx;
        logic [DIST_W-1:0]   near_dist;
    } t_tok;

endpackage

`default_nettype wire

>>> rtl/core/pnc_req_if.sv
// ----------------------------------------------------------------------------
// pnc_req_if
// request channel: valid/ready with mode, entry index and color
// ----------------------------------------------------------------------------
`default_nettype none

interface pnc_req_if;
    import pnc_pkg::*;

    logic                valid;
    logic                ready;
    t_mode               mode;
    logic [IDX_W-1:0]    entry_index;
    logic [COLOR_W-1:0]  color;

    modport source (output valid, output mode, output entry_index, output color,
                    input ready);
    modport sink   (input valid, input mode, input entry_index, input color,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/pnc_rsp_if.sv
// ----------------------------------------------------------------------------
// pnc_rsp_if
// response channel: valid/ready with read color, found index and found flag
// ----------------------------------------------------------------------------
`default_nettype none

interface pnc_rsp_if;
    import pnc_pkg::*;

    logic                valid;
    logic                ready;
    logic [COLOR_W-1:0]  read_color;
    logic [IDX_W-1:0]    found_index;
    logic                found;

    modport source (output valid, output read_color, output found_index,
                    output found, input ready);
    modport sink   (input valid, input read_color, input found_index,
                    input found, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pnc_cell.sv
// ----------------------------------------------------------------------------
// pnc_cell
// one palette entry: applies the passing request to its entry and forwards it
// ----------------------------------------------------------------------------
`default_nettype none

module pnc_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_adv,
    input  pnc_pkg::t_tok  i_tok,
    output pnc_pkg::t_tok  o_tok
);
    import pnc_pkg::*;

    localparam logic IDX_OK = (CELL_IDX < (1 << IDX_W));
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 16'(d * d);
    endfunction

    logic [COLOR_W-1:0] r_entry;
    t_tok               r_tok;
    t_tok               n_tok;
    logic               w_match;
    logic [DIST_W-1:0]  w_dist;

    assign w_match = IDX_OK && (i_tok.entry_index == MY_IDX);

    assign w_dist = DIST_W'(sq_diff(i_tok.color[23:16], r_entry[23:16]))
                  + DIST_W'(sq_diff(i_tok.color[15:8],  r_entry[15:8]))
                  + DIST_W'(sq_diff(i_tok.color[7:0],   r_entry[7:0]));

    always_comb begin
        n_tok = i_tok;
        if (i_tok.mode == MODE_READ && w_match) begin
            n_tok.rd = r_entry;
        end
        if (!i_tok.ex_hit && r_entry == i_tok.color) begin
            n_tok.ex_hit = 1'b1;
            n_tok.ex_idx = MY_IDX;
        end
        if (w_dist < i_tok.near_dist) begin
            n_tok.near_hit  = 1'b1;
            n_tok.near_idx  = MY_IDX;
            n_tok.near_dist = w_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry   <= '0;
            r_tok.vld <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
            if (i_tok.vld && i_tok.mode == MODE_WRITE && w_match) begin
                r_entry <= i_tok.color;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

>>> rtl/core/palette_nearest_color_search_core.sv
// ----------------------------------------------------------------------------
// palette_nearest_color_search_core
// palette of ARGB colors with write, read, exact find and nearest find
// ----------------------------------------------------------------------------
// channel  dir  payload                             handshake
// i_req    in   mode, entry_index, color            valid/ready
// o_rsp    out  read_color, found_index, found      valid/ready
//
// each request walks the row of PALETTE_ENTRIES entry cells, one cell a cycle
// while the row is not held; one request in flight: the response register loads
// as the request leaves the last cell and ready rises in that same cycle
// a response still waiting when the next request reaches the row end holds the row
// reset clears every entry to zero and marks the palette unallocated
// ----------------------------------------------------------------------------
`default_nettype none

module palette_nearest_color_search_core #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    pnc_req_if.sink   i_req,
    pnc_rsp_if.source o_rsp
);
    import pnc_pkg::*;

    t_tok                       w_tok [0:PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] w_vld;
    t_tok                       w_end;
    logic                       w_accept;
    logic                       w_adv;
    logic                       w_load;

    logic                r_busy;
    logic                r_alloc;
    logic                r_out_vld;
    logic [COLOR_W-1:0]  r_read_color;
    logic [IDX_W-1:0]    r_found_index;
    logic                r_found;

    logic [COLOR_W-1:0]  n_read_color;
    logic [IDX_W-1:0]    n_found_index;
    logic                n_found;

    assign i_req.ready = !r_busy;
    assign w_accept    = i_req.valid && !r_busy;

    always_comb begin
        w_tok[0]             = '0;
        w_tok[0].vld         = w_accept;
        w_tok[0].mode        = i_req.mode;
        w_tok[0].entry_index = i_req.entry_index;
        w_tok[0].color       = i_req.color;
        w_tok[0].alloc       = r_alloc;
        w_tok[0].near_dist   = DIST_START;
    end

    genvar gi;
    generate
        for (gi = 0; gi < PALETTE_ENTRIES; gi++) begin : g_cell
            pnc_cell #(
                .CELL_IDX (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_tok   (w_tok[gi]),
                .o_tok   (w_tok[gi+1])
            );
            assign w_vld[gi] = w_tok[gi+1].vld;
        end
    endgenerate

    assign w_end  = w_tok[PALETTE_ENTRIES];
    assign w_load = w_end.vld && (!r_out_vld || o_rsp.ready);
    assign w_adv  = !(w_end.vld && r_out_vld && !o_rsp.ready);

    always_comb begin
        n_read_color  = '0;
        n_found_index = '0;
        n_found       = 1'b0;
        unique case (w_end.mode)
            MODE_WRITE: begin
            end
            MODE_READ: begin
                if (w_end.alloc) begin
                    n_read_color = w_end.rd;
                end
            end
            MODE_EXACT: begin
                if (w_end.alloc && w_end.ex_hit) begin
                    n_found       = 1'b1;
                    n_found_index = w_end.ex_idx;
                end
            end
            MODE_NEAREST: begin
                if (w_end.alloc) begin
                    if (w_end.ex_hit) begin
                        n_found       = 1'b1;
                        n_found_index = w_end.ex_idx;
                    end else if (w_end.near_hit) begin
                        n_found       = 1'b1;
                        n_found_index = w_end.near_idx;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_alloc   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                if (i_req.mode == MODE_WRITE) begin
                    r_alloc <= 1'b1;
                end
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_read_color  <= n_read_color;
            r_found_index <= n_found_index;
            r_found       <= n_found;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.read_color  = r_read_color;
    assign o_rsp.found_index = r_found_index;
    assign o_rsp.found       = r_found;

`ifndef SYNTH
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld))
        else $error("more than one request in the cell row");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (w_vld == '0))
        else $error("request in the cell row while idle");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> (o_rsp.found_index == '0))
        else $error("found index set without a find");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_busy && !i_req.ready))
        else $error("request accepted while another is in flight");
`endif

endmodule

`default_nettype wire
